// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the touch classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/tts_pkg.sv -----
// Types and constants of the touch tap and swipe classifier.
`timescale 1ns / 1ps

package tts_pkg;

   // Field widths.
   localparam int RAW_W   = 12;
   localparam int COORD_W = 10;
   localparam int PAGE_W  = 4;
   localparam int COUNT_W = 5;
   localparam int SLOT_W  = 4;
   localparam int POSX_W  = 9;
   localparam int POSY_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Calibration window of the raw readings.
   localparam int CAL_X_LO   = 200;
   localparam int CAL_Y_LO   = 240;
   localparam int CAL_HI     = 3800;
   localparam int CAL_X_SPAN = CAL_HI - CAL_X_LO;
   localparam int CAL_Y_SPAN = CAL_HI - CAL_Y_LO;
   // Fraction bits of the reciprocal scale factors.
   localparam int CAL_FRAC   = 24;
   localparam int CAL_MUL_W  = 24;

   // Cells along each axis of the button grid.
   localparam int GRID_N = 3;

   // Event codes of a result beat.
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_PRESS = 2'd1,
      EV_TAP   = 2'd2,
      EV_SWIPE = 2'd3
   } event_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAGE_COUNT  = 3'd0,
      REG_SWIPE_THR   = 3'd1,
      REG_GRID_X0     = 3'd2,
      REG_GRID_Y0     = 3'd3,
      REG_STEP_X      = 3'd4,
      REG_STEP_Y      = 3'd5,
      REG_CELL_W      = 3'd6,
      REG_CELL_H      = 3'd7
   } reg_index_type;

   // Reset values of the registers.
   localparam logic [PAGE_W-1:0]     RST_PAGE_COUNT = 4'd4;
   localparam logic [COORD_W-1:0]    RST_SWIPE_THR  = 10'd70;
   localparam logic [COORD_W-1:0]    RST_GRID_X0    = 10'd3;
   localparam logic [COORD_W-1:0]    RST_GRID_Y0    = 10'd26;
   localparam logic [COORD_W-1:0]    RST_STEP_X     = 10'd106;
   localparam logic [COORD_W-1:0]    RST_STEP_Y     = 10'd70;
   localparam logic [COORD_W-1:0]    RST_CELL_W     = 10'd101;
   localparam logic [COORD_W-1:0]    RST_CELL_H     = 10'd65;

   // Payload of one result beat.
   typedef struct packed {
      event_type           event_res;
      logic [SLOT_W-1:0]   slot;
      logic                slot_valid;
      logic [PAGE_W-1:0]   page;
      logic [POSX_W-1:0]   pos_x;
      logic [POSY_W-1:0]   pos_y;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/tts_if.sv -----
// Channel interfaces of the touch classifier: poll requests and event results.
`timescale 1ns / 1ps

interface tts_req_if;
   logic                       valid;
   logic                       ready;
   logic                       touched;
   logic [tts_pkg::RAW_W-1:0]  raw_x;
   logic [tts_pkg::RAW_W-1:0]  raw_y;

   modport source (output valid, touched, raw_x, raw_y, input ready);
   modport sink   (input valid, touched, raw_x, raw_y, output ready);
endinterface

interface tts_rsp_if;
   logic                        valid;
   logic                        ready;
   tts_pkg::event_type          event_res;
   logic [tts_pkg::SLOT_W-1:0]  slot;
   logic                        slot_valid;
   logic [tts_pkg::PAGE_W-1:0]  page;
   logic [tts_pkg::POSX_W-1:0]  pos_x;
   logic [tts_pkg::POSY_W-1:0]  pos_y;

   modport source (output valid, event_res, slot, slot_valid, page, pos_x, pos_y,
                   input ready);
   modport sink   (input valid, event_res, slot, slot_valid, page, pos_x, pos_y,
                   output ready);
endinterface

// ----- hw/rtl/touch_tap_swipe_classifier_top.sv -----
// Top level of the touch tap and swipe classifier.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one touch-panel poll per beat and returns exactly one result beat for it.
// A poll passes an input register and then a result register before its result
// is offered, and a new poll is taken in every cycle while the result side keeps
// up. The single stage between the two registers scales the raw reading by a
// constant reciprocal, clamps it, finds the grid cell and updates the press and
// page state. The press state and page carry from one poll to the next within
// that stage. The user must write registers through the csr_ port only while no
// poll is in flight; the block itself does not enforce this.
module touch_tap_swipe_classifier_top #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240,
   parameter int MAX_PAGES     = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   tts_req_if.sink                            req_bus,
   tts_rsp_if.source                          rsp_bus,
   input  logic                               csr_wen,
   input  logic [tts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = tts_pkg::COORD_W;
   localparam int RW = tts_pkg::RAW_W;
   localparam int MW = tts_pkg::CAL_MUL_W;
   localparam int PW = tts_pkg::PAGE_W;
   localparam int NW = tts_pkg::COUNT_W;

   // Rounded-up reciprocal scale factors: floor(d * size / span) is exact for
   // every raw offset because the rounding error stays below 1/span.
   localparam logic [47:0] CAL_X_MUL_W = ((48'(SCREEN_WIDTH) << tts_pkg::CAL_FRAC)
                                          + 48'(tts_pkg::CAL_X_SPAN) - 48'd1)
                                         / 48'(tts_pkg::CAL_X_SPAN);
   localparam logic [47:0] CAL_Y_MUL_W = ((48'(SCREEN_HEIGHT) << tts_pkg::CAL_FRAC)
                                          + 48'(tts_pkg::CAL_Y_SPAN) - 48'd1)
                                         / 48'(tts_pkg::CAL_Y_SPAN);
   localparam logic [MW-1:0] CAL_X_MUL = CAL_X_MUL_W[MW-1:0];
   localparam logic [MW-1:0] CAL_Y_MUL = CAL_Y_MUL_W[MW-1:0];
   localparam logic [CW-1:0] X_MAX     = CW'(SCREEN_WIDTH - 1);
   localparam logic [CW-1:0] Y_MAX     = CW'(SCREEN_HEIGHT - 1);
   localparam logic [RW-1:0] X_LO      = RW'(tts_pkg::CAL_X_LO);
   localparam logic [RW-1:0] Y_LO      = RW'(tts_pkg::CAL_Y_LO);
   localparam logic [NW-1:0] MAX_CNT   = NW'(MAX_PAGES);

   // Configuration registers.
   logic [PW-1:0] cfg_page_count_ff;
   logic [CW-1:0] cfg_swipe_thr_ff;
   logic [CW-1:0] cfg_grid_x0_ff;
   logic [CW-1:0] cfg_grid_y0_ff;
   logic [CW-1:0] cfg_step_x_ff;
   logic [CW-1:0] cfg_step_y_ff;
   logic [CW-1:0] cfg_cell_w_ff;
   logic [CW-1:0] cfg_cell_h_ff;

   // Input register.
   logic          in_valid_ff;
   logic          in_touched_ff;
   logic [RW-1:0] in_raw_x_ff;
   logic [RW-1:0] in_raw_y_ff;

   // Press and page state.
   logic          pressed_ff, pressed_in;
   logic [CW-1:0] start_x_ff, start_x_in;
   logic [CW-1:0] start_y_ff, start_y_in;
   logic [CW-1:0] last_x_ff, last_x_in;
   logic [CW-1:0] last_y_ff, last_y_in;
   logic [PW-1:0] page_ff, page_in;

   // Result register.
   logic                     out_valid_ff;
   tts_pkg::rsp_payload_type out_ff, out_in;

   logic advance;
   logic take;

   // Beat flow: the input register drains into the result register whenever the
   // latter is empty or being emptied.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign take          = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;

   // Effective page count, clamped to 1..MAX_PAGES.
   function automatic logic [NW-1:0] clamp_count(input logic [PW-1:0] pc);
      logic [NW-1:0] c;
      c = NW'(pc);
      if (c == '0) begin
         c = NW'(1);
      end else if (c > MAX_CNT) begin
         c = MAX_CNT;
      end
      return c;
   endfunction

   logic [NW-1:0] eff_count;
   assign eff_count = clamp_count(cfg_page_count_ff);

   // Calibration: offset, one constant multiplication, truncation and clamp.
   logic [RW-1:0]    off_x, off_y;
   logic [RW+MW-1:0] prod_x, prod_y;
   logic [RW-1:0]    quo_x, quo_y;
   logic [CW-1:0]    cal_x, cal_y;

   always_comb begin
      off_x  = in_raw_x_ff - X_LO;
      off_y  = in_raw_y_ff - Y_LO;
      prod_x = (RW+MW)'(off_x) * (RW+MW)'(CAL_X_MUL);
      prod_y = (RW+MW)'(off_y) * (RW+MW)'(CAL_Y_MUL);
      quo_x  = prod_x[tts_pkg::CAL_FRAC +: RW];
      quo_y  = prod_y[tts_pkg::CAL_FRAC +: RW];
      if (in_raw_x_ff < X_LO) begin
         cal_x = '0;
      end else if (quo_x > RW'(X_MAX)) begin
         cal_x = X_MAX;
      end else begin
         cal_x = quo_x[CW-1:0];
      end
      if (in_raw_y_ff < Y_LO) begin
         cal_y = '0;
      end else if (quo_y > RW'(Y_MAX)) begin
         cal_y = Y_MAX;
      end else begin
         cal_y = quo_y[CW-1:0];
      end
   end

   // Grid index along one axis: compare with up to three pitch multiples.
   // Returns GRID_N when off the grid; rem is the offset inside the pitch.
   function automatic logic [1:0] grid_axis(input  logic [CW-1:0] d,
                                            input  logic [CW-1:0] step,
                                            output logic [CW-1:0] rem);
      logic [CW+1:0] d_w, s1, s2, s3;
      logic [1:0]    k;
      d_w = (CW+2)'(d);
      s1  = (CW+2)'(step);
      s2  = s1 + s1;
      s3  = s2 + s1;
      if (d_w < s1) begin
         k   = 2'd0;
         rem = d;
      end else if (d_w < s2) begin
         k   = 2'd1;
         rem = CW'(d_w - s1);
      end else if (d_w < s3) begin
         k   = 2'd2;
         rem = CW'(d_w - s2);
      end else begin
         k   = 2'(tts_pkg::GRID_N);
         rem = '0;
      end
      return k;
   endfunction

   // Cell lookup for the press point or, on a tap, the start point.
   logic [CW-1:0]               pt_x, pt_y, dx, dy, rem_x, rem_y;
   logic [1:0]                  col, row;
   logic                        hit;
   logic [tts_pkg::SLOT_W-1:0]  hit_slot;

   always_comb begin
      pt_x = in_touched_ff ? cal_x : start_x_ff;
      pt_y = in_touched_ff ? cal_y : start_y_ff;
      dx   = pt_x - cfg_grid_x0_ff;
      dy   = pt_y - cfg_grid_y0_ff;
      col  = grid_axis(dx, cfg_step_x_ff, rem_x);
      row  = grid_axis(dy, cfg_step_y_ff, rem_y);
      hit  = (pt_x >= cfg_grid_x0_ff) && (pt_y >= cfg_grid_y0_ff)
             && (col != 2'(tts_pkg::GRID_N)) && (row != 2'(tts_pkg::GRID_N))
             && (rem_x < cfg_cell_w_ff) && (rem_y < cfg_cell_h_ff);
      hit_slot = tts_pkg::SLOT_W'(row) * tts_pkg::SLOT_W'(tts_pkg::GRID_N)
                 + tts_pkg::SLOT_W'(col);
   end

   // Horizontal travel of the press and the wrapped page neighbours.
   logic          travel_left;
   logic [CW-1:0] travel;
   logic [PW-1:0] page_fwd, page_back;

   always_comb begin
      travel_left = last_x_ff < start_x_ff;
      travel      = travel_left ? (start_x_ff - last_x_ff) : (last_x_ff - start_x_ff);
      page_fwd    = ((NW'(page_ff) + NW'(1)) >= eff_count) ? '0 : (page_ff + PW'(1));
      page_back   = (page_ff == '0) ? PW'(eff_count - NW'(1)) : (page_ff - PW'(1));
   end

   // Poll classification and next state.
   logic hit_used;

   always_comb begin
      pressed_in = pressed_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      page_in    = page_ff;
      hit_used   = 1'b0;
      out_in.event_res = tts_pkg::EV_NONE;
      out_in.pos_x     = '0;
      out_in.pos_y     = '0;

      if (advance) begin
         if (in_touched_ff) begin
            out_in.pos_x = tts_pkg::POSX_W'(cal_x);
            out_in.pos_y = tts_pkg::POSY_W'(cal_y);
            if (!pressed_ff) begin
               pressed_in       = 1'b1;
               start_x_in       = cal_x;
               start_y_in       = cal_y;
               out_in.event_res = tts_pkg::EV_PRESS;
               hit_used         = 1'b1;
            end
            last_x_in = cal_x;
            last_y_in = cal_y;
         end else if (pressed_ff) begin
            pressed_in = 1'b0;
            if (travel > cfg_swipe_thr_ff) begin
               out_in.event_res = tts_pkg::EV_SWIPE;
               page_in          = travel_left ? page_fwd : page_back;
            end else begin
               out_in.event_res = tts_pkg::EV_TAP;
               hit_used         = 1'b1;
            end
         end
      end

      // A new page count drops a page that no longer exists.
      if (csr_wen && (csr_index == tts_pkg::REG_PAGE_COUNT)
          && (NW'(page_ff) >= clamp_count(csr_wdata[PW-1:0]))) begin
         page_in = '0;
      end

      out_in.slot_valid = hit_used && hit;
      out_in.slot       = (hit_used && hit) ? hit_slot : '0;
      out_in.page       = page_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_page_count_ff <= tts_pkg::RST_PAGE_COUNT;
         cfg_swipe_thr_ff  <= tts_pkg::RST_SWIPE_THR;
         cfg_grid_x0_ff    <= tts_pkg::RST_GRID_X0;
         cfg_grid_y0_ff    <= tts_pkg::RST_GRID_Y0;
         cfg_step_x_ff     <= tts_pkg::RST_STEP_X;
         cfg_step_y_ff     <= tts_pkg::RST_STEP_Y;
         cfg_cell_w_ff     <= tts_pkg::RST_CELL_W;
         cfg_cell_h_ff     <= tts_pkg::RST_CELL_H;
      end else if (csr_wen) begin
         unique case (csr_index)
            tts_pkg::REG_PAGE_COUNT: cfg_page_count_ff <= csr_wdata[PW-1:0];
            tts_pkg::REG_SWIPE_THR:  cfg_swipe_thr_ff  <= csr_wdata;
            tts_pkg::REG_GRID_X0:    cfg_grid_x0_ff    <= csr_wdata;
            tts_pkg::REG_GRID_Y0:    cfg_grid_y0_ff    <= csr_wdata;
            tts_pkg::REG_STEP_X:     cfg_step_x_ff     <= csr_wdata;
            tts_pkg::REG_STEP_Y:     cfg_step_y_ff     <= csr_wdata;
            tts_pkg::REG_CELL_W:     cfg_cell_w_ff     <= csr_wdata;
            tts_pkg::REG_CELL_H:     cfg_cell_h_ff     <= csr_wdata;
         endcase
      end
   end

   // Input register: captures a poll beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_touched_ff <= req_bus.touched;
         in_raw_x_ff   <= req_bus.raw_x;
         in_raw_y_ff   <= req_bus.raw_y;
      end
   end

   // Press and page state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         page_ff    <= '0;
      end else begin
         pressed_ff <= pressed_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         page_ff    <= page_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.event_res  = out_ff.event_res;
   assign rsp_bus.slot       = out_ff.slot;
   assign rsp_bus.slot_valid = out_ff.slot_valid;
   assign rsp_bus.page       = out_ff.page;
   assign rsp_bus.pos_x      = out_ff.pos_x;
   assign rsp_bus.pos_y      = out_ff.pos_y;

   // Checks on the classifier state.
   `TTS_ASSERT_NOW(a_page_in_range, clock, reset, 1'b1, NW'(page_ff) < eff_count)
   `TTS_ASSERT_NOW(a_press_from_touch, clock, reset, $rose(pressed_ff),
                   $past(advance && in_touched_ff))
   `TTS_ASSERT_NEXT(a_release_clears, clock, reset, advance && !in_touched_ff,
                    !pressed_ff)
   `TTS_ASSERT_NOW(a_slot_cleared, clock, reset, out_valid_ff && !out_ff.slot_valid,
                   out_ff.slot == '0)

endmodule

// ----- sim/tb_touch_tap_swipe_classifier_top.sv -----
// Self-checking testbench of the touch tap and swipe classifier: directed polls, random gestures.
`timescale 1ns / 1ps

module tb_touch_tap_swipe_classifier_top;
   import tts_pkg::*;

   localparam int SCREEN_WIDTH    = 320;
   localparam int SCREEN_HEIGHT   = 240;
   localparam int MAX_PAGES       = 12;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int BURST_POLLS     = 40;
   localparam int WATCHDOG_LIMIT  = 1000;

   // Register settings that a phase of the run may use.
   typedef enum {SET_DEFAULT, SET_ZERO, SET_MAX, SET_TYPICAL, SET_WILD} setting_kind;

   // One poll of the directed part, with its result typed in where it is obvious.
   typedef struct packed {
      logic                touched;
      logic [RAW_W-1:0]    raw_x;
      logic [RAW_W-1:0]    raw_y;
      logic                has_want;
      rsp_payload_type     want;
   } poll_row_type;

   logic clock;
   logic reset;
   logic csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tts_req_if req_if ();
   tts_rsp_if rsp_if ();

   touch_tap_swipe_classifier_top #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_PAGES     (MAX_PAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers and of the press and page state.
   logic [PAGE_W-1:0]  pg_count;
   logic [COORD_W-1:0] swipe_thr, grid_x0, grid_y0, step_x, step_y, cell_w, cell_h;
   bit                 is_pressed;
   int unsigned        first_x, first_y, latest_x, latest_y, page_now;

   rsp_payload_type expected_q [$];
   int  errors         = 0;
   int  idle_cycles    = 0;
   int  polls_in_phase = 0;
   bit  sender_quiet   = 0;
   bit  receiver_quiet = 0;
   bit  hold_off_pending = 0;

   // Directed polls: extremes, every event, the gap between buttons and the exact threshold.
   poll_row_type directed_rows [0:20] = '{
      '{1'b0, 12'd0,    12'd0,    1'b1, '{EV_NONE,  4'd0, 1'b0, 4'd0, 9'd0,   8'd0}},
      '{1'b1, 12'd0,    12'd0,    1'b1, '{EV_PRESS, 4'd0, 1'b0, 4'd0, 9'd0,   8'd0}},
      '{1'b1, 12'd4095, 12'd4095, 1'b1, '{EV_NONE,  4'd0, 1'b0, 4'd0, 9'd319, 8'd239}},
      '{1'b0, 12'd4095, 12'd4095, 1'b1, '{EV_SWIPE, 4'd0, 1'b0, 4'd3, 9'd0,   8'd0}},
      '{1'b0, 12'd0,    12'd0,    1'b1, '{EV_NONE,  4'd0, 1'b0, 4'd3, 9'd0,   8'd0}},
      '{1'b1, 12'd763,  12'd982,  1'b0, '0},
      '{1'b0, 12'd0,    12'd0,    1'b0, '0},
      '{1'b1, 12'd2000, 12'd2020, 1'b0, '0},
      '{1'b1, 12'd3575, 12'd2020, 1'b0, '0},
      '{1'b0, 12'd0,    12'd0,    1'b0, '0},
      '{1'b1, 12'd3575, 12'd3207, 1'b0, '0},
      '{1'b1, 12'd2000, 12'd3207, 1'b0, '0},
      '{1'b0, 12'd0,    12'd0,    1'b0, '0},
      '{1'b1, 12'd1382, 12'd982,  1'b0, '0},
      '{1'b1, 12'd199,  12'd239,  1'b0, '0},
      '{1'b0, 12'd0,    12'd0,    1'b0, '0},
      '{1'b1, 12'd1325, 12'd982,  1'b0, '0},
      '{1'b1, 12'd2113, 12'd982,  1'b0, '0},
      '{1'b0, 12'd0,    12'd0,    1'b0, '0},
      '{1'b1, 12'd3800, 12'd3800, 1'b0, '0},
      '{1'b0, 12'd0,    12'd0,    1'b0, '0}
   };

   setting_kind schedule [0:9] = '{
      SET_TYPICAL, SET_ZERO, SET_TYPICAL, SET_MAX, SET_WILD,
      SET_TYPICAL, SET_TYPICAL, SET_DEFAULT, SET_WILD, SET_TYPICAL
   };

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Maps a raw reading to screen pixels, truncating and saturating.
   function automatic int unsigned scale_raw(int unsigned raw, int unsigned lo, int unsigned size);
      int unsigned v;
      if (raw < lo) return 0;
      v = (raw - lo) * size / (CAL_HI - lo);
      if (v > size - 1) v = size - 1;
      return v;
   endfunction

   // Column or row of an offset along one axis; GRID_N means off the grid.
   function automatic int unsigned axis_cell(int unsigned d, int unsigned pitch);
      for (int unsigned k = 0; k < GRID_N; k++)
         if (d < (k + 1) * pitch) return k;
      return GRID_N;
   endfunction

   // Finds the button under a point, if there is one.
   function automatic bit button_at(int unsigned x, int unsigned y,
                                    output logic [SLOT_W-1:0] slot_idx);
      int unsigned dx, dy, col, row;
      slot_idx = '0;
      if (x < grid_x0 || y < grid_y0) return 0;
      dx  = x - grid_x0;
      dy  = y - grid_y0;
      col = axis_cell(dx, step_x);
      row = axis_cell(dy, step_y);
      if (col >= GRID_N || row >= GRID_N) return 0;
      if (dx - col * step_x >= cell_w) return 0;
      if (dy - row * step_y >= cell_h) return 0;
      slot_idx = SLOT_W'(row * GRID_N + col);
      return 1;
   endfunction

   // Number of pages that a swipe wraps over, with out-of-range counts pulled in.
   function automatic int unsigned page_limit();
      int unsigned n;
      n = pg_count;
      if (n < 1) n = 1;
      if (n > MAX_PAGES) n = MAX_PAGES;
      return n;
   endfunction

   // Works out the result beat of one poll and advances the shadow state.
   function automatic rsp_payload_type predict_poll(bit touch, logic [RAW_W-1:0] rx,
                                                    logic [RAW_W-1:0] ry);
      rsp_payload_type r;
      int unsigned x, y, n;
      int travel, magnitude;
      logic [SLOT_W-1:0] slot_idx;
      bit on_button;
      x = 0;
      y = 0;
      on_button = 0;
      slot_idx = '0;
      r.event_res = EV_NONE;
      if (touch) begin
         x = scale_raw(rx, CAL_X_LO, SCREEN_WIDTH);
         y = scale_raw(ry, CAL_Y_LO, SCREEN_HEIGHT);
         if (!is_pressed) begin
            is_pressed  = 1;
            first_x     = x;
            first_y     = y;
            r.event_res = EV_PRESS;
            on_button   = button_at(x, y, slot_idx);
         end
         latest_x = x;
         latest_y = y;
      end else if (is_pressed) begin
         travel     = int'(latest_x) - int'(first_x);
         magnitude  = travel < 0 ? -travel : travel;
         is_pressed = 0;
         if (magnitude > int'(swipe_thr)) begin
            // Leftward travel turns the page forward, rightward travel back.
            n = page_limit();
            r.event_res = EV_SWIPE;
            if (travel < 0) page_now = (page_now + 1) % n;
            else page_now = (page_now + n - 1) % n;
         end else begin
            r.event_res = EV_TAP;
            on_button   = button_at(first_x, first_y, slot_idx);
         end
         if (page_now >= page_limit()) page_now = 0;
      end
      if (!on_button) slot_idx = '0;
      r.slot       = slot_idx;
      r.slot_valid = on_button;
      r.page       = PAGE_W'(page_now);
      r.pos_x      = POSX_W'(x);
      r.pos_y      = POSY_W'(y);
      return r;
   endfunction

   // Raw reading, mostly inside the calibration window.
   function automatic logic [RAW_W-1:0] rand_raw();
      if ($urandom_range(0, 4) == 0) return RAW_W'($urandom_range(0, 4095));
      return RAW_W'($urandom_range(CAL_X_LO, CAL_HI));
   endfunction

   // Drags a raw reading by up to span counts either way.
   function automatic logic [RAW_W-1:0] move_raw(logic [RAW_W-1:0] raw, int span);
      int v;
      v = int'(raw) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return RAW_W'(v);
   endfunction

   // Offers one poll beat and records what it must produce once it is taken.
   task automatic send_poll(bit touch, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                            bit has_want, rsp_payload_type want);
      int gap;
      rsp_payload_type predicted;
      gap = sender_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.touched <= touch;
      req_if.raw_x   <= rx;
      req_if.raw_y   <= ry;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = predict_poll(touch, rx, ry);
      expected_q.push_back(has_want ? want : predicted);
      polls_in_phase++;
   endtask

   // Stops offering polls until every outstanding result beat has come back.
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Writes one register and mirrors it in the shadow copy.
   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_PAGE_COUNT: begin
            pg_count = value[PAGE_W-1:0];
            if (page_now >= page_limit()) page_now = 0;
         end
         REG_SWIPE_THR: swipe_thr = value;
         REG_GRID_X0:   grid_x0   = value;
         REG_GRID_Y0:   grid_y0   = value;
         REG_STEP_X:    step_x    = value;
         REG_STEP_Y:    step_y    = value;
         REG_CELL_W:    cell_w    = value;
         REG_CELL_H:    cell_h    = value;
         default: ;
      endcase
   endtask

   // Loads a whole register setting while the block is idle.
   task automatic apply_setting(setting_kind kind);
      logic [CSR_DATA_W-1:0] vals [8];
      int sx, sy;
      case (kind)
         SET_DEFAULT: begin
            vals = '{CSR_DATA_W'(RST_PAGE_COUNT), RST_SWIPE_THR, RST_GRID_X0, RST_GRID_Y0,
                     RST_STEP_X, RST_STEP_Y, RST_CELL_W, RST_CELL_H};
         end
         SET_ZERO: begin
            foreach (vals[i]) vals[i] = '0;
         end
         SET_MAX: begin
            foreach (vals[i]) vals[i] = '1;
         end
         SET_TYPICAL: begin
            sx = $urandom_range(20, 120);
            sy = $urandom_range(20, 90);
            vals[REG_PAGE_COUNT] = CSR_DATA_W'($urandom_range(1, MAX_PAGES));
            vals[REG_SWIPE_THR]  = CSR_DATA_W'($urandom_range(0, 200));
            vals[REG_GRID_X0]    = CSR_DATA_W'($urandom_range(0, 40));
            vals[REG_GRID_Y0]    = CSR_DATA_W'($urandom_range(0, 40));
            vals[REG_STEP_X]     = CSR_DATA_W'(sx);
            vals[REG_STEP_Y]     = CSR_DATA_W'(sy);
            vals[REG_CELL_W]     = CSR_DATA_W'($urandom_range(1, sx));
            vals[REG_CELL_H]     = CSR_DATA_W'($urandom_range(1, sy));
         end
         default: begin
            foreach (vals[i]) vals[i] = CSR_DATA_W'($urandom_range(0, 1023));
         end
      endcase
      foreach (vals[i]) write_reg(reg_index_type'(i), vals[i]);
      csr_wen <= 1'b0;
   endtask

   // Result side: a random stall before each beat, or one long hold-off on request.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_pending = 0;
         end else if (receiver_quiet) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // Task to print one differing field of a result beat.
   task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
   endtask

   // Compares every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.event_res, rsp_if.slot, rsp_if.slot_valid, rsp_if.page,
                rsp_if.pos_x, rsp_if.pos_y};
         if (expected_q.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, got %p", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.event_res !== want.event_res)
               report_field("event_res", want.event_res, got.event_res);
            if (got.slot !== want.slot) report_field("slot", want.slot, got.slot);
            if (got.slot_valid !== want.slot_valid)
               report_field("slot_valid", want.slot_valid, got.slot_valid);
            if (got.page !== want.page) report_field("page", want.page, got.page);
            if (got.pos_x !== want.pos_x) report_field("pos_x", want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y) report_field("pos_y", want.pos_y, got.pos_y);
         end
      end
      // Count cycles in which no beat moves on either channel.
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   // Watchdog against a hung handshake.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus: reset, directed polls, then phases of random gestures.
   initial begin
      logic [RAW_W-1:0] rx, ry;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.touched <= 1'b0;
      req_if.raw_x   <= '0;
      req_if.raw_y   <= '0;
      csr_wen        <= 1'b0;
      csr_index      <= REG_PAGE_COUNT;
      csr_wdata      <= '0;
      pg_count  = RST_PAGE_COUNT;
      swipe_thr = RST_SWIPE_THR;
      grid_x0   = RST_GRID_X0;
      grid_y0   = RST_GRID_Y0;
      step_x    = RST_STEP_X;
      step_y    = RST_STEP_Y;
      cell_w    = RST_CELL_W;
      cell_h    = RST_CELL_H;
      is_pressed = 0;
      first_x    = 0;
      first_y    = 0;
      latest_x   = 0;
      latest_y   = 0;
      page_now   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_poll(directed_rows[i].touched, directed_rows[i].raw_x, directed_rows[i].raw_y,
                   directed_rows[i].has_want, directed_rows[i].want);
      wait_for_results();

      foreach (schedule[p]) begin
         apply_setting(schedule[p]);
         polls_in_phase = 0;
         receiver_quiet = (p == 5);
         // One phase starts with a long hold-off on the result side under a dense burst.
         if (p == 6) hold_off_pending = 1;
         while (polls_in_phase < ITEMS_PER_PHASE) begin
            sender_quiet = (p == 5) || (p == 6 && polls_in_phase < BURST_POLLS);
            if ($urandom_range(0, 9) < 8) begin
               // A well-formed gesture: press, a few drags, release.
               rx = rand_raw();
               ry = rand_raw();
               send_poll(1'b1, rx, ry, 1'b0, '0);
               repeat ($urandom_range(0, 5)) begin
                  rx = move_raw(rx, 1200);
                  ry = move_raw(ry, 300);
                  send_poll(1'b1, rx, ry, 1'b0, '0);
               end
               send_poll(1'b0, RAW_W'($urandom), RAW_W'($urandom), 1'b0, '0);
            end else begin
               send_poll(1'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                         1'b0, '0);
            end
            if ($urandom_range(0, 60) == 0) wait_for_results();
         end
         wait_for_results();
      end

      sender_quiet = 0;
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t ns: %0d result beats never arrived", $time, expected_q.size());
         errors++;
      end
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_if.sv
hw/rtl/touch_tap_swipe_classifier_top.sv
sim/tb_touch_tap_swipe_classifier_top.sv
